### rtl/core/assert_macros.svh
// assertion macros shared by the deframer modules
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define PLDF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked property, checked in every cycle including reset
`define PLDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/pldf_pkg.sv
// types and constants for the preamble/length packet deframer
// no dependencies; imported by every module of the block
`default_nettype none

package pldf_pkg;

   localparam logic       CMD_BYTE      = 1'b0;
   localparam logic       CMD_RESTART   = 1'b1;

   localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
   localparam int         PREAMBLE_LEN   = 3;
   localparam int         HEADER_LEN     = 6;
   localparam int         FRAME_OVERHEAD = 8;

   // wide enough for length plus frame overhead
   localparam int         CMP_W = 17;

   localparam logic [2:0] PH_PREAMBLE = 3'd0;
   localparam logic [2:0] PH_ID       = 3'd1;
   localparam logic [2:0] PH_LENGTH   = 3'd2;
   localparam logic [2:0] PH_PAYLOAD  = 3'd3;
   localparam logic [2:0] PH_CHECKSUM = 3'd4;
   localparam logic [2:0] PH_DONE     = 3'd5;
   localparam logic [2:0] PH_ERROR    = 3'd6;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [10:0] byte_position;
      logic [15:0] payload_length;
      logic [7:0]  packet_id;
      logic [7:0]  data_byte;
      logic        byte_taken;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/pldf_parser.sv
// phase machine, byte counter and header decode of the deframer
// depends on pldf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pldf_parser
   import pldf_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type in_data,
   output rsp_type      out_data
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);

   typedef enum logic [6:0] {
      ST_PREAMBLE = 7'b0000001,
      ST_ID       = 7'b0000010,
      ST_LENGTH   = 7'b0000100,
      ST_PAYLOAD  = 7'b0001000,
      ST_CHECKSUM = 7'b0010000,
      ST_DONE     = 7'b0100000,
      ST_ERROR    = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in, count_inc;
   logic [7:0]       low_ff, low_in;
   logic [15:0]      len_ff, len_in, len_cat;
   logic [7:0]       id_ff, id_in;
   logic             taken;
   logic [2:0]       phase;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      low_in    = low_ff;
      len_in    = len_ff;
      id_in     = id_ff;
      taken     = 1'b0;
      count_inc = count_ff + 1'b1;
      len_cat   = {in_data.rx_byte, low_ff};
      if (in_data.cmd == CMD_RESTART) begin
         state_in = ST_PREAMBLE;
         count_in = '0;
         low_in   = '0;
         len_in   = '0;
         id_in    = '0;
      end else begin
         case (state_ff)
            ST_PREAMBLE: begin
               taken    = 1'b1;
               count_in = count_inc;
               if (in_data.rx_byte != PREAMBLE_BYTE) begin
                  state_in = ST_ERROR;
               end else if (count_inc == CNT_W'(PREAMBLE_LEN)) begin
                  state_in = ST_ID;
               end
            end
            ST_ID: begin
               taken    = 1'b1;
               count_in = count_inc;
               id_in    = in_data.rx_byte;
               state_in = ST_LENGTH;
            end
            ST_LENGTH: begin
               taken    = 1'b1;
               count_in = count_inc;
               if (count_inc == CNT_W'(HEADER_LEN - 1)) begin
                  low_in = in_data.rx_byte;
               end else begin
                  len_in = len_cat;
                  if (len_cat > 16'(MAX_PAYLOAD)) begin
                     state_in = ST_ERROR;
                  end else if (len_cat != 16'd0) begin
                     state_in = ST_PAYLOAD;
                  end else begin
                     state_in = ST_CHECKSUM;
                  end
               end
            end
            ST_PAYLOAD: begin
               taken    = 1'b1;
               count_in = count_inc;
               if (CMP_W'(count_inc) == CMP_W'(len_ff) + CMP_W'(HEADER_LEN)) begin
                  state_in = ST_CHECKSUM;
               end
            end
            ST_CHECKSUM: begin
               taken    = 1'b1;
               count_in = count_inc;
               if (CMP_W'(count_inc) == CMP_W'(len_ff) + CMP_W'(FRAME_OVERHEAD)) begin
                  state_in = ST_DONE;
               end
            end
            ST_DONE: begin
               state_in = ST_ERROR;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (state_in)
         ST_PREAMBLE: phase = PH_PREAMBLE;
         ST_ID:       phase = PH_ID;
         ST_LENGTH:   phase = PH_LENGTH;
         ST_PAYLOAD:  phase = PH_PAYLOAD;
         ST_CHECKSUM: phase = PH_CHECKSUM;
         ST_DONE:     phase = PH_DONE;
         default:     phase = PH_ERROR;
      endcase
   end

   always_comb begin
      out_data.phase          = phase;
      out_data.byte_position  = 11'(count_in);
      out_data.payload_length = len_in;
      out_data.packet_id      = id_in;
      out_data.data_byte      = taken ? in_data.rx_byte : 8'd0;
      out_data.byte_taken     = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PREAMBLE;
         count_ff <= '0;
         low_ff   <= '0;
         len_ff   <= '0;
         id_ff    <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
         low_ff   <= low_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
      end
   end

   `PLDF_ASSERT(a_restart_clears, clock, reset, !reset && accept && in_data.cmd == CMD_RESTART |=> state_ff == ST_PREAMBLE && count_ff == '0 && len_ff == 16'd0, "restart did not clear the parser")
   `PLDF_ASSERT(a_error_holds, clock, reset, !reset && accept && in_data.cmd == CMD_BYTE && state_ff == ST_ERROR |=> state_ff == ST_ERROR && count_ff == $past(count_ff), "error phase changed without restart")
   `PLDF_ASSERT(a_payload_bound, clock, reset, state_ff == ST_PAYLOAD |-> CMP_W'(count_ff) < CMP_W'(len_ff) + CMP_W'(HEADER_LEN), "byte count ran past the payload end")

endmodule

`default_nettype wire

### rtl/core/pldf_skid.sv
// two-entry result buffer between the parser and the result channel
// depends on pldf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pldf_skid
   import pldf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire rsp_type in_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rsp_type      out_data
);

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    push;
   logic    pop;

   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign push      = in_valid && !skid_valid_ff;
   assign pop       = main_valid_ff && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else if (push) begin
            main_ff <= in_data;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_ff <= in_data;
         end else begin
            main_ff <= in_data;
         end
      end
   end

   `PLDF_ASSERT_ALWAYS(a_skid_needs_main, clock, reset || !skid_valid_ff || main_valid_ff, "skid entry held with empty output stage")
   `PLDF_ASSERT(a_skid_kept, clock, reset, !reset && skid_valid_ff && out_stall |=> skid_valid_ff && $stable(skid_ff), "skid entry lost while output stalled")

endmodule

`default_nettype wire

### rtl/core/preamble_length_packet_deframer.sv
// top level of the preamble/length packet deframer: parser and result buffer
// depends on pldf_pkg, pldf_parser and pldf_skid
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_data  (cmd, rx_byte)
//   rsp      out  rsp_valid / rsp_stall  rsp_data  (phase .. byte_taken)
//
// one item per cycle while req_stall is low; each item gives one result, registered in the output buffer
// the phase machine and counter update in the same cycle as the item is taken
// a two-entry output buffer lets one more item in while a result is stalled
// req_stall rises only when both buffer entries are held
// synchronous reset returns to waiting for preamble with an empty buffer
`default_nettype none

module preamble_length_packet_deframer
   import pldf_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    accept;
   rsp_type result;

   assign accept = req_valid && !req_stall;

   pldf_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_data  (req_data),
      .out_data (result)
   );

   pldf_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire
